### sv/sic_pkg.sv
`timescale 1ns / 1ps
// Shared interrupt controller package: source count, widths and item kind codes.
// No dependencies.
package sic_pkg;

	localparam int unsigned NUM_IRQS = 64;
	localparam int unsigned IRQ_W    = 64;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [IRQ_W-1:0] SRC_SPAN = (NUM_IRQS >= IRQ_W) ? {IRQ_W{1'b1}} :
		((IRQ_W'(1) << NUM_IRQS) - IRQ_W'(1));

	localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MASK_SET = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MASK_CLR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PEND_SET = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PEND_CLR = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_EDGE_SELECT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 1'd1;

endpackage

### sv/sic_prio_enc.sv
`timescale 1ns / 1ps
// Highest-set-bit encoder over the source vector, two levels of eight.
// Depends on sic_pkg.
module sic_prio_enc import sic_pkg::*; (
	input  logic [IRQ_W-1:0] vec,
	output logic             any,
	output logic [IDX_W-1:0] top
);

	logic [7:0]      grp_any;
	logic [2:0]      grp_idx [8];
	logic [2:0]      hi_grp;

	always_comb begin
		for (int g = 0; g < 8; g++) begin
			grp_any[g] = |vec[g*8 +: 8];
			grp_idx[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (vec[g*8 + b]) begin
					grp_idx[g] = 3'(b);
				end
			end
		end
		hi_grp = 3'd0;
		for (int g = 0; g < 8; g++) begin
			if (grp_any[g]) begin
				hi_grp = 3'(g);
			end
		end
	end

	assign any = |grp_any;
	assign top = {hi_grp, grp_idx[hi_grp]};

endmodule

### sv/shared_interrupt_controller.sv
`timescale 1ns / 1ps
// Shared interrupt controller: mask, edge/level pending and priority encode.
// Input beat path: input register, then result register; out_stall can hold a beat in either.
// Throughput: one beat per cycle unless stalled; state update and 64-bit encode sit between them.
// Reset (arst_n low, async): masks, pending and sampled lines clear, edge_select 0,
// active_high all ones, pipeline empty. Depends on sic_pkg and sic_prio_enc.
module shared_interrupt_controller import sic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IRQ_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [KIND_W-1:0]    kind,
	input  logic [IRQ_W-1:0]     source_lines,
	input  logic [IDX_W-1:0]     source_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IRQ_W-1:0]     masked_pending,
	output logic                 any_pending,
	output logic [IDX_W-1:0]     top_source
);

	logic [IRQ_W-1:0]  edge_select_q, active_high_q;
	logic [IRQ_W-1:0]  enable_mask_q, edge_pending_q, previous_lines_q;

	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [IRQ_W-1:0]  lines_s1;
	logic [IDX_W-1:0]  index_s1;

	logic              valid_s2;
	logic [IRQ_W-1:0]  masked_s2;
	logic              any_s2;
	logic [IDX_W-1:0]  top_s2;

	logic              advance;
	logic              in_range;
	logic [IRQ_W-1:0]  bit_sel;
	logic [IRQ_W-1:0]  enable_nxt, pend_nxt, prev_nxt;
	logic [IRQ_W-1:0]  was_act, now_act, masked_nxt;
	logic              any_nxt;
	logic [IDX_W-1:0]  top_nxt;

	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;

	assign in_range = {1'b0, index_s1} < (IDX_W + 1)'(NUM_IRQS);
	assign bit_sel  = IRQ_W'(1) << index_s1;
	assign was_act  = ~(previous_lines_q ^ active_high_q);
	assign now_act  = ~(lines_s1 ^ active_high_q);

	always_comb begin
		enable_nxt = enable_mask_q;
		pend_nxt   = edge_pending_q;
		prev_nxt   = previous_lines_q;
		unique case (kind_s1)
			KIND_SAMPLE: begin
				pend_nxt = edge_pending_q | (now_act & ~was_act & edge_select_q & SRC_SPAN);
				prev_nxt = lines_s1;
			end
			KIND_MASK_SET: if (in_range) enable_nxt = enable_mask_q | bit_sel;
			KIND_MASK_CLR: if (in_range) enable_nxt = enable_mask_q & ~bit_sel;
			KIND_PEND_SET: if (in_range) pend_nxt = edge_pending_q | bit_sel;
			KIND_PEND_CLR: if (in_range) pend_nxt = edge_pending_q & ~bit_sel;
			default: ;
		endcase
		masked_nxt = ((pend_nxt & edge_select_q) | (~(prev_nxt ^ active_high_q) & ~edge_select_q))
			& enable_nxt & SRC_SPAN;
	end

	sic_prio_enc u_enc (
		.vec (masked_nxt),
		.any (any_nxt),
		.top (top_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_select_q <= '0;
			active_high_q <= '1;
		end else if (cfg_we) begin
			if (cfg_index == REG_EDGE_SELECT) edge_select_q <= cfg_data;
			if (cfg_index == REG_ACTIVE_HIGH) active_high_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q    <= '0;
			edge_pending_q   <= '0;
			previous_lines_q <= '0;
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
		end else begin
			if (advance) begin
				enable_mask_q    <= enable_nxt;
				edge_pending_q   <= pend_nxt;
				previous_lines_q <= prev_nxt;
			end
			if (!in_stall) valid_s1 <= in_valid;
			if (advance) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1  <= kind;
			lines_s1 <= source_lines;
			index_s1 <= source_index;
		end
		if (advance) begin
			masked_s2 <= masked_nxt;
			any_s2    <= any_nxt;
			top_s2    <= top_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign masked_pending = masked_s2;
	assign any_pending    = any_s2;
	assign top_source     = top_s2;

`ifndef ASSERT_OFF
	a_any_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (any_pending == (masked_pending != '0)))
		else $error("any_pending disagrees with masked_pending");

	a_top_is_highest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && any_pending) |-> ((masked_pending >> top_source) == IRQ_W'(1)))
		else $error("top_source is not the highest pending source");

	a_none_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !any_pending) |-> (top_source == '0))
		else $error("top_source nonzero with nothing pending");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");
`endif

endmodule

### tb/sv/shared_interrupt_controller_tb.sv
`timescale 1ns / 1ps
// Testbench for shared_interrupt_controller: a directed table, then random phases under
// several trigger/polarity settings, results checked against the table or a bench model.
// Depends on sic_pkg and the controller RTL.
module shared_interrupt_controller_tb;
	import sic_pkg::*;

	localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

	localparam logic [IRQ_W-1:0] NONE     = '0;
	localparam logic [IRQ_W-1:0] ALL_ONES = '1;
	localparam logic [IRQ_W-1:0] LO_HALF  = 64'h0000_0000_FFFF_FFFF;
	localparam logic [IRQ_W-1:0] HI_HALF  = 64'hFFFF_FFFF_0000_0000;
	localparam logic [IRQ_W-1:0] BIT63    = 64'h8000_0000_0000_0000;

	localparam int LONG_HOLD    = 300;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		logic [IRQ_W-1:0] masked;
		logic             any;
		logic [IDX_W-1:0] top;
	} irq_report_t;

	// cfg rows: drain, then load edge_select from lines and active_high from aux
	typedef struct packed {
		logic              cfg;
		logic [KIND_W-1:0] kind;
		logic [IRQ_W-1:0]  lines;
		logic [IDX_W-1:0]  idx;
		logic [IRQ_W-1:0]  aux;
		logic              typed;
		logic [IRQ_W-1:0]  masked;
		logic              any;
		logic [IDX_W-1:0]  top;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [0:25] = '{
		'{1'b0, KIND_SAMPLE,   ALL_ONES, 6'd0,  NONE, 1'b1, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_MASK_SET, NONE,     6'd63, NONE, 1'b1, BIT63, 1'b1, 6'd63},
		'{1'b0, KIND_MASK_SET, NONE,     6'd0,  NONE, 1'b1, BIT63 | 64'h1, 1'b1, 6'd63},
		'{1'b0, KIND_MASK_CLR, NONE,     6'd63, NONE, 1'b1, 64'h1, 1'b1, 6'd0},
		'{1'b0, KIND_MASK_SET, NONE,     6'd5,  NONE, 1'b1, 64'h21, 1'b1, 6'd5},
		'{1'b0, KIND_SAMPLE,   NONE,     6'd0,  NONE, 1'b1, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_PEND_SET, NONE,     6'd5,  NONE, 1'b1, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_RSVD5,    ALL_ONES, 6'd0,  NONE, 1'b1, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_RSVD6,    ALL_ONES, 6'd5,  NONE, 1'b1, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_RSVD7,    ALL_ONES, 6'd63, NONE, 1'b1, NONE, 1'b0, 6'd0},
		'{1'b1, KIND_SAMPLE,   ALL_ONES, 6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_MASK_SET, NONE,     6'd40, NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_SAMPLE,   ALL_ONES, 6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_SAMPLE,   NONE,     6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_PEND_CLR, NONE,     6'd40, NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_PEND_CLR, NONE,     6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_PEND_SET, NONE,     6'd63, NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_MASK_SET, NONE,     6'd63, NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_SAMPLE,   LO_HALF,  6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b1, KIND_SAMPLE,   HI_HALF,  6'd0,  LO_HALF, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_MASK_SET, NONE,     6'd31, NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_MASK_SET, NONE,     6'd32, NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_SAMPLE,   HI_HALF,  6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_SAMPLE,   LO_HALF,  6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_SAMPLE,   NONE,     6'd0,  NONE, 1'b0, NONE, 1'b0, 6'd0},
		'{1'b0, KIND_PEND_CLR, NONE,     6'd63, NONE, 1'b0, NONE, 1'b0, 6'd0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [IRQ_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [KIND_W-1:0]    kind;
	logic [IRQ_W-1:0]     source_lines;
	logic [IDX_W-1:0]     source_index;
	logic                 out_valid;
	logic                 out_stall;
	logic [IRQ_W-1:0]     masked_pending;
	logic                 any_pending;
	logic [IDX_W-1:0]     top_source;

	// model state
	logic [IRQ_W-1:0] cfg_edge_sel;
	logic [IRQ_W-1:0] cfg_act_high;
	logic [IRQ_W-1:0] irq_enable;
	logic [IRQ_W-1:0] irq_latched;
	logic [IRQ_W-1:0] irq_prev_lines;

	irq_report_t awaited_reports [$];
	int          fail_count = 0;
	int          burst_left = 0;
	bit          hold_req = 1'b0;
	logic [IRQ_W-1:0] last_lines = '0;

	shared_interrupt_controller dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.source_lines   (source_lines),
		.source_index   (source_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.masked_pending (masked_pending),
		.any_pending    (any_pending),
		.top_source     (top_source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic irq_report_t next_irq_report(input logic [KIND_W-1:0] k,
			input logic [IRQ_W-1:0] lines, input logic [IDX_W-1:0] idx);
		logic [IRQ_W-1:0] onehot;
		logic [IRQ_W-1:0] was_active;
		logic [IRQ_W-1:0] now_active;
		logic [IRQ_W-1:0] pend;
		logic             in_span;
		irq_report_t      rep;
		onehot  = IRQ_W'(1) << idx;
		in_span = (int'(idx) < int'(NUM_IRQS));
		case (k)
			KIND_SAMPLE: begin
				was_active = ~(irq_prev_lines ^ cfg_act_high);
				now_active = ~(lines ^ cfg_act_high);
				irq_latched |= now_active & ~was_active & cfg_edge_sel & SRC_SPAN;
				irq_prev_lines = lines;
			end
			KIND_MASK_SET: if (in_span) irq_enable |= onehot;
			KIND_MASK_CLR: if (in_span) irq_enable &= ~onehot;
			KIND_PEND_SET: if (in_span) irq_latched |= onehot;
			KIND_PEND_CLR: if (in_span) irq_latched &= ~onehot;
			default: ;
		endcase
		pend = (irq_latched & cfg_edge_sel) | (~(irq_prev_lines ^ cfg_act_high) & ~cfg_edge_sel);
		rep.masked = pend & irq_enable & SRC_SPAN;
		rep.any    = |rep.masked;
		rep.top    = '0;
		for (int i = 0; i < IRQ_W; i++) begin
			if (rep.masked[i]) rep.top = IDX_W'(i);
		end
		return rep;
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [IRQ_W-1:0] lines,
			input logic [IDX_W-1:0] idx, input bit typed, input irq_report_t typed_rep);
		int gap;
		int r;
		irq_report_t rep;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 8) burst_left = $urandom_range(20, 60);
			else if (r < 45) gap = 0;
			else if (r < 85) gap = $urandom_range(1, 3);
			else if (r < 96) gap = $urandom_range(4, 10);
			else gap = $urandom_range(15, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		source_lines <= lines;
		source_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		rep = next_irq_report(k, lines, idx);
		awaited_reports.push_back(typed ? typed_rep : rep);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [IRQ_W-1:0] es, input logic [IRQ_W-1:0] ah);
		cfg_we    <= 1'b1;
		cfg_index <= REG_EDGE_SELECT;
		cfg_data  <= es;
		@(posedge clk);
		cfg_index <= REG_ACTIVE_HIGH;
		cfg_data  <= ah;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_edge_sel = es;
		cfg_act_high = ah;
	endtask

	task automatic check_report();
		irq_report_t want;
		if (awaited_reports.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTED)
				$display("unexpected result beat: masked %h any %b top %0d",
					masked_pending, any_pending, top_source);
		end else begin
			want = awaited_reports.pop_front();
			if (masked_pending !== want.masked || any_pending !== want.any ||
					top_source !== want.top) begin
				fail_count++;
				if (fail_count <= MAX_REPORTED)
					$display("mismatch: masked exp %h got %h, any exp %b got %b, top exp %0d got %0d",
						want.masked, masked_pending, want.any, any_pending,
						want.top, top_source);
			end
		end
	endtask

	// result side: random stalls, free-running stretches, one long hold on request
	initial begin : result_side
		int hold;
		int free;
		int r;
		hold = 0;
		free = 0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) check_report();
			if (hold_req) begin
				hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold == 0 && free == 0) begin
				r = $urandom_range(0, 99);
				if (r < 10) free = $urandom_range(20, 80);
				else if (r < 13) hold = $urandom_range(10, 40);
				else if (r < 40) hold = $urandom_range(1, 3);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
				if (free > 0) free--;
			end
		end
	end

	initial begin : stimulus
		irq_report_t      typed_rep;
		logic [KIND_W-1:0] k;
		logic [IRQ_W-1:0]  lines;
		logic [IDX_W-1:0]  idx;
		logic [IRQ_W-1:0]  es;
		logic [IRQ_W-1:0]  ah;
		int r;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_EDGE_SELECT;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		kind         <= KIND_SAMPLE;
		source_lines <= '0;
		source_index <= '0;
		cfg_edge_sel   = '0;
		cfg_act_high   = '1;
		irq_enable     = '0;
		irq_latched    = '0;
		irq_prev_lines = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i]) begin
			if (DIR_TAB[i].cfg) begin
				settle();
				write_config(DIR_TAB[i].lines, DIR_TAB[i].aux);
			end else begin
				typed_rep.masked = DIR_TAB[i].masked;
				typed_rep.any    = DIR_TAB[i].any;
				typed_rep.top    = DIR_TAB[i].top;
				send_item(DIR_TAB[i].kind, DIR_TAB[i].lines, DIR_TAB[i].idx,
					DIR_TAB[i].typed, typed_rep);
			end
		end

		typed_rep = '0;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin es = NONE;     ah = ALL_ONES; end
				1: begin es = ALL_ONES; ah = NONE;     end
				2: begin es = ALL_ONES; ah = ALL_ONES; end
				3: begin es = NONE;     ah = NONE;     end
				default: begin
					es = {$urandom, $urandom};
					ah = {$urandom, $urandom};
				end
			endcase
			settle();
			write_config(es, ah);
			if (p == 1) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 35) k = KIND_SAMPLE;
				else if (r < 50) k = KIND_MASK_SET;
				else if (r < 60) k = KIND_MASK_CLR;
				else if (r < 75) k = KIND_PEND_SET;
				else if (r < 95) k = KIND_PEND_CLR;
				else k = KIND_RSVD5 + KIND_W'($urandom_range(0, 2));
				r = $urandom_range(0, 99);
				if (r < 25)
					lines = last_lines ^ (IRQ_W'(1) << $urandom_range(0, 63))
						^ (IRQ_W'(1) << $urandom_range(0, 63));
				else if (r < 35) lines = NONE;
				else if (r < 45) lines = ALL_ONES;
				else lines = {$urandom, $urandom};
				r = $urandom_range(0, 99);
				if (r < 8) idx = '0;
				else if (r < 16) idx = '1;
				else idx = IDX_W'($urandom_range(0, 63));
				if (k == KIND_SAMPLE) last_lines = lines;
				send_item(k, lines, idx, 1'b0, typed_rep);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && awaited_reports.size() == 0) begin
			$display("shared_interrupt_controller regression: pass");
		end else begin
			$display("shared_interrupt_controller regression: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("shared_interrupt_controller regression: fail");
		$finish;
	end

endmodule
